// ===== sv/nsfc_pkg.sv =====
`timescale 1ns / 1ps

package nsfc_pkg;

    // character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // prefix pattern lengths
    localparam int GGA_LEN = 6;
    localparam int RMC_LEN = 6;
    localparam int HW_LEN  = 8;

    // prefix match flag positions
    localparam int PM_GGA = 0;
    localparam int PM_RMC = 1;
    localparam int PM_HW  = 2;

    localparam int LEN_W = 7;

    // status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD     = 2'd1;
    localparam logic [1:0] STATUS_NO_STAR = 2'd2;

    // sentence kind codes
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_GGA   = 2'd1;
    localparam logic [1:0] KIND_RMC   = 2'd2;
    localparam logic [1:0] KIND_HW    = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       sentence_kind;
        logic [7:0]       computed_sum;
        logic [7:0]       received_sum;
        logic             received_too_long;
        logic [LEN_W-1:0] sentence_length;
        logic [15:0]      restart_total;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    // "$GPGGA"
    function automatic logic [7:0] gga_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h47;
            3'd4:    c = 8'h47;
            3'd5:    c = 8'h41;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "$GPRMC"
    function automatic logic [7:0] rmc_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4d;
            3'd5:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "$HW Type"
    function automatic logic [7:0] hw_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h24;
            3'd1: c = 8'h48;
            3'd2: c = 8'h57;
            3'd3: c = 8'h20;
            3'd4: c = 8'h54;
            3'd5: c = 8'h79;
            3'd6: c = 8'h70;
            3'd7: c = 8'h65;
        endcase
        return c;
    endfunction

    // ascii hex digit decode, both letter cases
    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b0;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h57);
        end
        return h;
    endfunction

endpackage

// ===== sv/nsfc_byte_if.sv =====
`timescale 1ns / 1ps

interface nsfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/nsfc_result_if.sv =====
`timescale 1ns / 1ps

interface nsfc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  sentence_kind;
    logic [7:0]  computed_sum;
    logic [7:0]  received_sum;
    logic        received_too_long;
    logic [6:0]  sentence_length;
    logic [15:0] restart_total;

    modport source (
        output valid, output status, output sentence_kind, output computed_sum,
        output received_sum, output received_too_long, output sentence_length,
        output restart_total, input ready
    );
    modport sink (
        input valid, input status, input sentence_kind, input computed_sum,
        input received_sum, input received_too_long, input sentence_length,
        input restart_total, output ready
    );
endinterface

// ===== sv/nsfc_framer.sv =====
`timescale 1ns / 1ps

module nsfc_framer #(
    parameter int MAX_SENTENCE = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output logic                o_emit,
    output nsfc_pkg::t_result   o_result
);

    localparam int POS_W = $clog2(MAX_SENTENCE);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_SENTENCE - 1);

    logic             r_collecting, n_collecting;
    logic [POS_W-1:0] r_position, n_position;
    logic [7:0]       r_running_xor, n_running_xor;
    logic             r_star_seen, n_star_seen;
    logic             r_hex_scanning, n_hex_scanning;
    logic [7:0]       r_hex_value, n_hex_value;
    logic             r_hex_overflow, n_hex_overflow;
    logic             r_text_ended, n_text_ended;
    logic [2:0]       r_prefix_match, n_prefix_match;
    logic [15:0]      r_restart_count, n_restart_count;

    nsfc_pkg::t_hex   hex;
    logic [2:0]       prefix_hit;
    logic [1:0]       status;
    logic [1:0]       kind;

    assign hex = nsfc_pkg::hex_digit(i_byte);

    // prefix compare against the byte at the current position
    always_comb begin
        prefix_hit = r_prefix_match;
        if (r_position < POS_W'(nsfc_pkg::GGA_LEN)
            && i_byte != nsfc_pkg::gga_char(r_position[2:0])) begin
            prefix_hit[nsfc_pkg::PM_GGA] = 1'b0;
        end
        if (r_position < POS_W'(nsfc_pkg::RMC_LEN)
            && i_byte != nsfc_pkg::rmc_char(r_position[2:0])) begin
            prefix_hit[nsfc_pkg::PM_RMC] = 1'b0;
        end
        if (r_position < POS_W'(nsfc_pkg::HW_LEN)
            && i_byte != nsfc_pkg::hw_char(r_position[2:0])) begin
            prefix_hit[nsfc_pkg::PM_HW] = 1'b0;
        end
    end

    // report fields from the held sentence state
    always_comb begin
        if (!r_star_seen) begin
            status = nsfc_pkg::STATUS_NO_STAR;
        end else if (r_hex_overflow || r_hex_value != r_running_xor) begin
            status = nsfc_pkg::STATUS_BAD;
        end else begin
            status = nsfc_pkg::STATUS_OK;
        end

        priority if (r_prefix_match[nsfc_pkg::PM_GGA]
                     && r_position >= POS_W'(nsfc_pkg::GGA_LEN)) begin
            kind = nsfc_pkg::KIND_GGA;
        end else if (r_prefix_match[nsfc_pkg::PM_RMC]
                     && r_position >= POS_W'(nsfc_pkg::RMC_LEN)) begin
            kind = nsfc_pkg::KIND_RMC;
        end else if (r_prefix_match[nsfc_pkg::PM_HW]
                     && r_position >= POS_W'(nsfc_pkg::HW_LEN)) begin
            kind = nsfc_pkg::KIND_HW;
        end else begin
            kind = nsfc_pkg::KIND_OTHER;
        end
    end

    // next state for one byte
    always_comb begin
        n_collecting    = r_collecting;
        n_position      = r_position;
        n_running_xor   = r_running_xor;
        n_star_seen     = r_star_seen;
        n_hex_scanning  = r_hex_scanning;
        n_hex_value     = r_hex_value;
        n_hex_overflow  = r_hex_overflow;
        n_text_ended    = r_text_ended;
        n_prefix_match  = r_prefix_match;
        n_restart_count = r_restart_count;
        o_emit          = 1'b0;

        if (i_step) begin
            if (!r_collecting) begin
                // hunting for the dollar
                if (i_byte == nsfc_pkg::CH_DOLLAR) begin
                    n_collecting   = 1'b1;
                    n_position     = POS_W'(1);
                    n_running_xor  = 8'd0;
                    n_star_seen    = 1'b0;
                    n_hex_scanning = 1'b0;
                    n_hex_value    = 8'd0;
                    n_hex_overflow = 1'b0;
                    n_text_ended   = 1'b0;
                    n_prefix_match = 3'b111;
                end
            end else if (r_position >= POS_LIMIT) begin
                // buffer full, drop sentence
                n_collecting = 1'b0;
            end else if (i_byte == nsfc_pkg::CH_CR) begin
                n_collecting = r_collecting;
            end else if (i_byte != nsfc_pkg::CH_LF) begin
                if (!r_text_ended) begin
                    n_prefix_match = prefix_hit;
                    if (i_byte == nsfc_pkg::CH_NUL) begin
                        n_text_ended   = 1'b1;
                        n_hex_scanning = 1'b0;
                    end else if (!r_star_seen) begin
                        if (i_byte == nsfc_pkg::CH_STAR) begin
                            n_star_seen    = 1'b1;
                            n_hex_scanning = 1'b1;
                        end else begin
                            n_running_xor = r_running_xor ^ i_byte;
                        end
                    end else if (r_hex_scanning) begin
                        if (!hex.ok) begin
                            n_hex_scanning = 1'b0;
                        end else begin
                            n_hex_overflow = r_hex_overflow | (|r_hex_value[7:4]);
                            n_hex_value    = {r_hex_value[3:0], hex.value};
                        end
                    end
                end
                n_position = r_position + POS_W'(1);
            end else begin
                // line feed closes the sentence
                n_collecting = 1'b0;
                o_emit       = 1'b1;
                if (status == nsfc_pkg::STATUS_OK && kind == nsfc_pkg::KIND_HW) begin
                    n_restart_count = r_restart_count + 16'd1;
                end
            end
        end
    end

    always_comb begin
        o_result.status            = status;
        o_result.sentence_kind     = kind;
        o_result.computed_sum      = r_running_xor;
        o_result.received_sum      = r_star_seen ? r_hex_value : 8'd0;
        o_result.received_too_long = r_star_seen & r_hex_overflow;
        o_result.sentence_length   = nsfc_pkg::LEN_W'(r_position);
        o_result.restart_total     = n_restart_count;
    end

    // sentence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting    <= 1'b0;
            r_position      <= '0;
            r_running_xor   <= 8'd0;
            r_star_seen     <= 1'b0;
            r_hex_scanning  <= 1'b0;
            r_hex_value     <= 8'd0;
            r_hex_overflow  <= 1'b0;
            r_text_ended    <= 1'b0;
            r_prefix_match  <= 3'b111;
            r_restart_count <= 16'd0;
        end else begin
            r_collecting    <= n_collecting;
            r_position      <= n_position;
            r_running_xor   <= n_running_xor;
            r_star_seen     <= n_star_seen;
            r_hex_scanning  <= n_hex_scanning;
            r_hex_value     <= n_hex_value;
            r_hex_overflow  <= n_hex_overflow;
            r_text_ended    <= n_text_ended;
            r_prefix_match  <= n_prefix_match;
            r_restart_count <= n_restart_count;
        end
    end

endmodule

// ===== sv/nmea_sentence_framer_checker_unit.sv =====
`timescale 1ns / 1ps
// nmea sentence framer and checksum checker, one byte per request
// throughput: one byte per cycle while the result side is not stalled, both sides may stream continuously
// a line feed's result passes through the input register,
// then the result register
// reset: synchronous active low; hunts for a dollar, restart count zero

module nmea_sentence_framer_checker_unit #(
    parameter int MAX_SENTENCE = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    nsfc_byte_if.sink            i_rx,
    nsfc_result_if.source        o_res
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    nsfc_pkg::t_result r_out;

    logic              advance;
    logic              emit;
    nsfc_pkg::t_result result;

    // held byte moves on when the result slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    nsfc_framer #(
        .MAX_SENTENCE(MAX_SENTENCE)
    ) u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_emit  (emit),
        .o_result(result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.status            = r_out.status;
    assign o_res.sentence_kind     = r_out.sentence_kind;
    assign o_res.computed_sum      = r_out.computed_sum;
    assign o_res.received_sum      = r_out.received_sum;
    assign o_res.received_too_long = r_out.received_too_long;
    assign o_res.sentence_length   = r_out.sentence_length;
    assign o_res.restart_total     = r_out.restart_total;

`ifndef NO_ASSERTIONS
    // a stalled result keeps the held byte in place
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !o_res.ready |=> r_in_valid)
        else $error("held byte lost while result stalled");

    // an accepted request always lands in the input register
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rx.valid && i_rx.ready |=> r_in_valid)
        else $error("accepted byte not held");

    // hex overflow forces a mismatch
    a_overflow_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.received_too_long |-> o_res.status == nsfc_pkg::STATUS_BAD)
        else $error("overflow without mismatch status");

    // without a star there is no received checksum
    a_no_star_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status == nsfc_pkg::STATUS_NO_STAR
        |-> o_res.received_sum == 8'd0 && !o_res.received_too_long)
        else $error("received checksum without star");
`endif

endmodule

// ===== bench/tb_nmea_sentence_framer_checker_unit.sv =====
`timescale 1ns / 1ps

module tb_nmea_sentence_framer_checker_unit;

    localparam int MAX_SENTENCE   = 128;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 380;
    localparam int MAX_SHOWN      = 50;

    // one directed line: head text, a run of one byte value, tail text
    typedef struct {
        string             head;
        int                fill_n;
        logic [7:0]        fill_b;
        string             tail;
        bit                typed;
        nsfc_pkg::t_result want;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    nsfc_byte_if   rx_if ();
    nsfc_result_if res_if ();

    nmea_sentence_framer_checker_unit #(
        .MAX_SENTENCE(MAX_SENTENCE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the framer state
    bit          in_sentence;
    logic [7:0]  held_count;
    logic [7:0]  xor_acc;
    bit          star_found;
    bit          hex_active;
    logic [7:0]  hex_acc;
    bit          hex_big;
    bit          nul_seen;
    logic [2:0]  kind_flags;
    logic [15:0] restarts;

    string gga_txt = "$GPGGA";
    string rmc_txt = "$GPRMC";
    string hw_txt  = "$HW Type";

    nsfc_pkg::t_result sentence_reports [$];
    t_row              rows [$];
    logic [7:0]        line_q [$];

    bit                typed_armed;
    nsfc_pkg::t_result typed_want;
    bit                src_quiet;
    bit                snk_quiet;
    bit                hold_req;
    int                errors;
    int                shown;
    int                bytes_sent;
    int                reports_checked;
    int                random_bytes;
    int                idle_cycles;
    nsfc_pkg::t_result head_report;

    // fresh sentence after a dollar
    function automatic void clear_sentence();
        held_count = 8'd1;
        xor_acc    = 8'd0;
        star_found = 1'b0;
        hex_active = 1'b0;
        hex_acc    = 8'd0;
        hex_big    = 1'b0;
        nul_seen   = 1'b0;
        kind_flags = 3'b111;
    endfunction

    // knock out prefix patterns that disagree at this position
    function automatic void match_prefix(logic [7:0] idx, logic [7:0] c);
        if (idx < nsfc_pkg::GGA_LEN && c != gga_txt[idx]) kind_flags[nsfc_pkg::PM_GGA] = 1'b0;
        if (idx < nsfc_pkg::RMC_LEN && c != rmc_txt[idx]) kind_flags[nsfc_pkg::PM_RMC] = 1'b0;
        if (idx < nsfc_pkg::HW_LEN && c != hw_txt[idx]) kind_flags[nsfc_pkg::PM_HW] = 1'b0;
    endfunction

    // advance the shadow state by one byte, report on line feed
    task automatic frame_byte(input logic [7:0] c, output bit got,
                              output nsfc_pkg::t_result rep);
        logic [3:0] nib;
        bit         is_hex;
        got = 1'b0;
        rep = '0;
        if (!in_sentence) begin
            if (c == nsfc_pkg::CH_DOLLAR) begin
                clear_sentence();
                in_sentence = 1'b1;
            end
            return;
        end
        // full buffer swallows this byte and drops the sentence
        if (held_count >= MAX_SENTENCE - 1) begin
            in_sentence = 1'b0;
            return;
        end
        if (c == nsfc_pkg::CH_CR) return;
        if (c != nsfc_pkg::CH_LF) begin
            if (!nul_seen) begin
                match_prefix(held_count, c);
                if (c == nsfc_pkg::CH_NUL) begin
                    nul_seen   = 1'b1;
                    hex_active = 1'b0;
                end else if (!star_found) begin
                    if (c == nsfc_pkg::CH_STAR) begin
                        star_found = 1'b1;
                        hex_active = 1'b1;
                    end else begin
                        xor_acc ^= c;
                    end
                end else if (hex_active) begin
                    is_hex = 1'b1;
                    nib    = 4'd0;
                    if (c >= "0" && c <= "9") nib = 4'(c - "0");
                    else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
                    else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
                    else is_hex = 1'b0;
                    if (!is_hex) begin
                        hex_active = 1'b0;
                    end else begin
                        if (hex_acc[7:4] != 4'd0) hex_big = 1'b1;
                        hex_acc = {hex_acc[3:0], nib};
                    end
                end
            end
            held_count++;
            return;
        end
        // line feed closes the sentence
        in_sentence = 1'b0;
        if (!star_found) rep.status = nsfc_pkg::STATUS_NO_STAR;
        else if (hex_big || hex_acc != xor_acc) rep.status = nsfc_pkg::STATUS_BAD;
        else rep.status = nsfc_pkg::STATUS_OK;
        rep.sentence_kind = nsfc_pkg::KIND_OTHER;
        if (kind_flags[nsfc_pkg::PM_GGA] && held_count >= nsfc_pkg::GGA_LEN)
            rep.sentence_kind = nsfc_pkg::KIND_GGA;
        else if (kind_flags[nsfc_pkg::PM_RMC] && held_count >= nsfc_pkg::RMC_LEN)
            rep.sentence_kind = nsfc_pkg::KIND_RMC;
        else if (kind_flags[nsfc_pkg::PM_HW] && held_count >= nsfc_pkg::HW_LEN)
            rep.sentence_kind = nsfc_pkg::KIND_HW;
        if (rep.status == nsfc_pkg::STATUS_OK && rep.sentence_kind == nsfc_pkg::KIND_HW)
            restarts++;
        rep.computed_sum      = xor_acc;
        rep.received_sum      = star_found ? hex_acc : 8'd0;
        rep.received_too_long = star_found && hex_big;
        rep.sentence_length   = held_count[nsfc_pkg::LEN_W-1:0];
        rep.restart_total     = restarts;
        got = 1'b1;
    endtask

    function automatic nsfc_pkg::t_result mk_report(logic [1:0] st, logic [1:0] kind,
                                                    logic [7:0] cs, logic [7:0] rs,
                                                    logic tl, logic [6:0] len,
                                                    logic [15:0] rt);
        nsfc_pkg::t_result r;
        r.status            = st;
        r.sentence_kind     = kind;
        r.computed_sum      = cs;
        r.received_sum      = rs;
        r.received_too_long = tl;
        r.sentence_length   = len;
        r.restart_total     = rt;
        return r;
    endfunction

    function automatic void add_row(string head, int fill_n, logic [7:0] fill_b, string tail,
                                    bit typed = 1'b0, nsfc_pkg::t_result want = '0);
        t_row row;
        row.head   = head;
        row.fill_n = fill_n;
        row.fill_b = fill_b;
        row.tail   = tail;
        row.typed  = typed;
        row.want   = want;
        rows.push_back(row);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endfunction

    // offer one byte, with random gaps, and predict once it is taken
    task automatic send_byte(input logic [7:0] b);
        bit                got;
        nsfc_pkg::t_result rep;
        if (!src_quiet) begin
            while ($urandom_range(99) < 20) begin
                rx_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        bytes_sent++;
        frame_byte(b, got, rep);
        if (got) sentence_reports.push_back(typed_armed ? typed_want : rep);
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_byte(line_q[i]);
    endtask

    // random sentence, with one added defect when broken; its checksum text is sometimes wrong
    task automatic build_sentence(input bit broken);
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [7:0]  rnd8;
        logic [11:0] rnd12;
        logic [3:0]  rnd4;
        int          n;
        int          star_at;
        string       txt;
        line_q.delete();
        line_q.push_back(nsfc_pkg::CH_DOLLAR);
        case ($urandom_range(3))
            0:       push_text("GPGGA");
            1:       push_text("GPRMC");
            2:       push_text("HW Type");
            default: ;
        endcase
        n = ($urandom_range(19) == 0) ? $urandom_range(100, 125) : $urandom_range(0, 12);
        repeat (n) begin
            b = 8'($urandom_range(1, 255));
            if (b == nsfc_pkg::CH_LF || b == nsfc_pkg::CH_CR || b == nsfc_pkg::CH_STAR) b = "x";
            line_q.push_back(b);
        end
        sum = 8'd0;
        for (int i = 1; i < line_q.size(); i++) sum ^= line_q[i];
        star_at = line_q.size();
        line_q.push_back(nsfc_pkg::CH_STAR);
        rnd8  = 8'($urandom);
        rnd12 = 12'($urandom);
        rnd4  = 4'($urandom);
        case ($urandom_range(9))
            0:       txt = $sformatf("%h", rnd8);
            1:       txt = $sformatf("%h", rnd12);
            2:       txt = $sformatf("%h", rnd4);
            3:       txt = "";
            default: txt = $sformatf("%h", sum);
        endcase
        if ($urandom_range(1)) txt = txt.toupper();
        push_text(txt);
        if ($urandom_range(1)) line_q.push_back(nsfc_pkg::CH_CR);
        line_q.push_back(nsfc_pkg::CH_LF);
        if (broken) begin
            case ($urandom_range(3))
                0:       line_q.insert($urandom_range(1, line_q.size() - 1), nsfc_pkg::CH_NUL);
                1:       line_q.delete(star_at);
                2:       void'(line_q.pop_back());
                default: line_q[$urandom_range(1, line_q.size() - 1)] = 8'($urandom);
            endcase
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            if (shown < MAX_SHOWN) begin
                shown++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        end
    endtask

    // result side: random stalls and one long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                res_if.ready <= snk_quiet || ($urandom_range(99) >= 20);
            end
        end
    end

    // compare each report with the oldest prediction
    always @(posedge i_clk) begin
        if (res_if.valid && res_if.ready) begin
            if (sentence_reports.size() == 0) begin
                errors++;
                if (shown < MAX_SHOWN) begin
                    shown++;
                    $display("%0t: report with none expected, expected nothing, got status %0h",
                             $time, res_if.status);
                end
            end else begin
                head_report = sentence_reports.pop_front();
                reports_checked++;
                check_field("status", head_report.status, res_if.status);
                check_field("sentence_kind", head_report.sentence_kind, res_if.sentence_kind);
                check_field("computed_sum", head_report.computed_sum, res_if.computed_sum);
                check_field("received_sum", head_report.received_sum, res_if.received_sum);
                check_field("received_too_long", head_report.received_too_long,
                            res_if.received_too_long);
                check_field("sentence_length", head_report.sentence_length,
                            res_if.sentence_length);
                check_field("restart_total", head_report.restart_total, res_if.restart_total);
            end
        end
    end

    // watchdog on cycles with no request taken on either side
    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d reports still pending", $time,
                         sentence_reports.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int r;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        in_sentence   = 1'b0;
        clear_sentence();
        held_count    = 8'd0;
        restarts      = 16'd0;

        // rows with typed reports first, while the restart count is known
        add_row("$*00", 1, nsfc_pkg::CH_CR, "\n", 1'b1,
                mk_report(nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_OTHER, 8'h00, 8'h00, 1'b0,
                          7'd4, 16'd0));
        add_row("$A\n", 0, 8'h00, "", 1'b1,
                mk_report(nsfc_pkg::STATUS_NO_STAR, nsfc_pkg::KIND_OTHER, 8'h41, 8'h00, 1'b0,
                          7'd2, 16'd0));
        add_row("$*100\n", 0, 8'h00, "", 1'b1,
                mk_report(nsfc_pkg::STATUS_BAD, nsfc_pkg::KIND_OTHER, 8'h00, 8'h00, 1'b1,
                          7'd5, 16'd0));
        add_row("$\n", 0, 8'h00, "", 1'b1,
                mk_report(nsfc_pkg::STATUS_NO_STAR, nsfc_pkg::KIND_OTHER, 8'h00, 8'h00, 1'b0,
                          7'd1, 16'd0));
        add_row("$GPGGA*56\n", 0, 8'h00, "", 1'b1,
                mk_report(nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_GGA, 8'h56, 8'h56, 1'b0,
                          7'd9, 16'd0));
        add_row("$GPGGA*57\n", 0, 8'h00, "", 1'b1,
                mk_report(nsfc_pkg::STATUS_BAD, nsfc_pkg::KIND_GGA, 8'h56, 8'h57, 1'b0,
                          7'd9, 16'd0));
        add_row("$GPRMC*4b\n", 0, 8'h00, "", 1'b1,
                mk_report(nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_RMC, 8'h4b, 8'h4b, 1'b0,
                          7'd9, 16'd0));
        add_row("$HW Type*07\n", 0, 8'h00, "", 1'b1,
                mk_report(nsfc_pkg::STATUS_OK, nsfc_pkg::KIND_HW, 8'h07, 8'h07, 1'b0,
                          7'd11, 16'd1));
        // ignored while hunting
        add_row("GP*", 1, 8'hff, "\n", 1'b0);
        // dollar inside, zero byte, short prefixes, hex forms
        add_row("$$GPGGA*56\n", 0, 8'h00, "");
        add_row("$GPGGA", 1, nsfc_pkg::CH_NUL, "*56\n");
        add_row("$GPG*12\n", 0, 8'h00, "");
        add_row("$HW Typ*62\n", 0, 8'h00, "");
        add_row("$HW Type*08\n", 0, 8'h00, "");
        add_row("$GPRMC*4B\n", 0, 8'h00, "");
        add_row("$*FFF\n", 0, 8'h00, "");
        add_row("$AB*4x3\n", 0, 8'h00, "");
        add_row("$*\n", 0, 8'h00, "");
        add_row("$*0", 1, nsfc_pkg::CH_NUL, "1\n");
        // buffer full drops the line, then the longest kept line
        add_row("$", 126, "A", "\n");
        add_row("Q\n", 0, 8'h00, "");
        add_row("$", 125, 8'hff, "\n");
        add_row("$HW Type*07", 1, nsfc_pkg::CH_CR, "\n");

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            line_q.delete();
            push_text(rows[i].head);
            repeat (rows[i].fill_n) line_q.push_back(rows[i].fill_b);
            push_text(rows[i].tail);
            typed_armed = rows[i].typed;
            typed_want  = rows[i].want;
            send_line();
            typed_armed = 1'b0;
        end

        // sender stops until every report is in
        rx_if.valid <= 1'b0;
        while (sentence_reports.size() != 0) @(posedge i_clk);

        // long hold-off on the result side while lines keep coming
        hold_req  = 1'b1;
        src_quiet = 1'b1;
        repeat (10) begin
            build_sentence(1'b0);
            send_line();
        end
        src_quiet = 1'b0;
        rx_if.valid <= 1'b0;
        while (sentence_reports.size() != 0) @(posedge i_clk);

        // random lines, mostly well formed, with a stretch of no idling
        while (random_bytes < RANDOM_BYTES) begin
            src_quiet = (random_bytes >= 120 && random_bytes < 260);
            snk_quiet = src_quiet;
            r = $urandom_range(99);
            if (r < 10) begin
                line_q.delete();
                repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom));
                send_line();
            end else begin
                build_sentence(r < 28);
                send_line();
                random_bytes += line_q.size();
            end
        end
        rx_if.valid <= 1'b0;

        while (sentence_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d bytes of directed and random lines, checked %0d reports",
                 bytes_sent, reports_checked);
        $display("restart count reached %0d, %0d field mismatches", restarts, errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
